### sv/hash_table_with_overflow_area_defines.svh
// Assertion macros for the hash table with overflow area.
// Used by the checker module; depends on nothing.
`ifndef HASH_TABLE_WITH_OVERFLOW_AREA_DEFINES_SVH
`define HASH_TABLE_WITH_OVERFLOW_AREA_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HTO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define HTO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/hto_pkg.sv
// Shared codes, field widths and modulo unit constants.
// Used by the top level and the checker; depends on nothing.
package hto_pkg;

    localparam int ITEM_W   = 31;
    localparam int OP_W     = 2;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 3;
    localparam int TS_W     = 7;
    localparam int OS_W     = 5;

    localparam logic [OP_W-1:0] OP_INSERT     = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE_POS = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_VAL = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    localparam logic [ITEM_W-1:0] NOTHING = 31'h7fffffff;

    localparam logic CFG_TABLE_SIZE    = 1'b0;
    localparam logic CFG_OVERFLOW_SIZE = 1'b1;

    localparam int MOD_STEPS = 4;
    localparam int MOD_ITER  = (ITEM_W + MOD_STEPS - 1) / MOD_STEPS;
    localparam int MOD_PAD_W = MOD_ITER * MOD_STEPS;
    localparam int MOD_IT_W  = (MOD_ITER > 1) ? $clog2(MOD_ITER) : 1;

endpackage

### sv/hto_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hto_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 80
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/hash_table_with_overflow_area.sv
// Hash table with home slots and a packed overflow area, one RAM for values.
// Depends on hto_pkg and hto_ram.
//
// channel   dir  handshake               payload
// in        in   in_valid / in_stall     operation, item_value, slot_position
// out       out  out_valid / out_stall   status, position, removed_value
// cfg       in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item at a time. A hash runs in the 4-bit-per-cycle modulo unit.
// Removing a home entry scans the overflow area for a refill, with one value-RAM
// read and one modulo per overflow entry scanned.
// Reset clears control state, occupancy bits and the overflow count; no RAM pass.
// A finished result waits in the output register while the next item is taken.
module hash_table_with_overflow_area #(
    parameter int HOME_SLOTS     = 64,
    parameter int OVERFLOW_SLOTS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [hto_pkg::OP_W-1:0]      operation,
    input  logic [hto_pkg::ITEM_W-1:0]    item_value,
    input  logic [hto_pkg::POS_W-1:0]     slot_position,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [hto_pkg::STATUS_W-1:0]  status,
    output logic [hto_pkg::POS_W-1:0]     position,
    output logic [hto_pkg::ITEM_W-1:0]    removed_value,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [hto_pkg::TS_W-1:0]      cfg_data
);

    localparam int TOTAL = HOME_SLOTS + OVERFLOW_SLOTS;
    localparam int IW    = $clog2(TOTAL);
    localparam int SW    = $clog2(TOTAL + 1);
    localparam int HW    = $clog2(HOME_SLOTS + 1);
    localparam int OW    = $clog2(OVERFLOW_SLOTS + 1);
    localparam int CW    = (SW > hto_pkg::POS_W) ? SW : hto_pkg::POS_W;

    typedef enum logic [3:0] {
        S_IDLE, S_MOD, S_HASHED, S_CHKHOME, S_SEARCH, S_SEARCH_CHK, S_POS,
        S_POS_HOME, S_POS_OVF, S_FH_RD, S_FH_LOAD, S_FH_CHK, S_DROP, S_DROP_WR,
        S_FINISH
    } state_t;

    state_t                         state_reg, state_next;
    state_t                         ret_reg, ret_next;
    logic [hto_pkg::TS_W-1:0]       table_size_reg;
    logic [hto_pkg::OS_W-1:0]       overflow_size_reg;
    logic [OW-1:0]                  count_reg, count_next;
    logic [TOTAL-1:0]               occ_reg, occ_next;
    logic [hto_pkg::OP_W-1:0]       op_reg, op_next;
    logic [hto_pkg::ITEM_W-1:0]     item_reg, item_next;
    logic [hto_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [HW-1:0]                  hs_reg, hs_next;
    logic [OW-1:0]                  os_reg, os_next;
    logic [OW-1:0]                  cnt_reg, cnt_next;
    logic [IW-1:0]                  h_reg, h_next;
    logic [OW-1:0]                  idx_reg, idx_next;
    logic [hto_pkg::ITEM_W-1:0]     val_reg, val_next;
    logic [hto_pkg::MOD_PAD_W-1:0]  num_reg, num_next;
    logic [HW-1:0]                  rem_reg, rem_next;
    logic [hto_pkg::MOD_IT_W-1:0]   iter_reg, iter_next;
    logic [hto_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [IW-1:0]                  res_where_reg, res_where_next;
    logic [hto_pkg::ITEM_W-1:0]     res_removed_reg, res_removed_next;
    logic                           out_valid_reg, out_valid_next;
    logic [hto_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [hto_pkg::POS_W-1:0]      position_reg, position_next;
    logic [hto_pkg::ITEM_W-1:0]     removed_reg, removed_next;

    logic                           ram_we;
    logic [IW-1:0]                  ram_waddr;
    logic [hto_pkg::ITEM_W-1:0]     ram_wdata;
    logic [IW-1:0]                  ram_raddr;
    logic [hto_pkg::ITEM_W-1:0]     ram_rdata;

    logic [HW-1:0]                  hs_eff;
    logic [OW-1:0]                  os_eff;
    logic [OW-1:0]                  cnt_eff;
    logic [IW-1:0]                  ovf_addr;
    logic [IW-1:0]                  app_addr;
    logic [IW-1:0]                  last_addr;
    logic [HW:0]                    mod_r;
    logic [hto_pkg::MOD_PAD_W-1:0]  mod_n;

    hto_ram #(
        .WIDTH (hto_pkg::ITEM_W),
        .DEPTH (TOTAL)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall      = (state_reg != S_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign position      = position_reg;
    assign removed_value = removed_reg;

    always_comb
    begin
        if (table_size_reg == '0)
        begin
            hs_eff = HW'(1);
        end
        else if (int'(table_size_reg) > HOME_SLOTS)
        begin
            hs_eff = HW'(HOME_SLOTS);
        end
        else
        begin
            hs_eff = HW'(table_size_reg);
        end
        if (int'(overflow_size_reg) > OVERFLOW_SLOTS)
        begin
            os_eff = OW'(OVERFLOW_SLOTS);
        end
        else
        begin
            os_eff = OW'(overflow_size_reg);
        end
        cnt_eff = (count_reg > os_eff) ? os_eff : count_reg;
    end

    assign ovf_addr  = IW'(SW'(hs_reg) + SW'(idx_reg));
    assign app_addr  = IW'(SW'(hs_reg) + SW'(cnt_reg));
    assign last_addr = IW'(SW'(hs_reg) + SW'(cnt_reg) - SW'(1));

    always_comb
    begin
        mod_r = {1'b0, rem_reg};
        mod_n = num_reg;
        for (int k = 0; k < hto_pkg::MOD_STEPS; k++)
        begin
            mod_r = {mod_r[HW-1:0], mod_n[hto_pkg::MOD_PAD_W-1]};
            mod_n = mod_n << 1;
            if (mod_r >= {1'b0, hs_reg})
            begin
                mod_r = mod_r - {1'b0, hs_reg};
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        ret_next         = ret_reg;
        count_next       = count_reg;
        occ_next         = occ_reg;
        op_next          = op_reg;
        item_next        = item_reg;
        pos_next         = pos_reg;
        hs_next          = hs_reg;
        os_next          = os_reg;
        cnt_next         = cnt_reg;
        h_next           = h_reg;
        idx_next         = idx_reg;
        val_next         = val_reg;
        num_next         = num_reg;
        rem_next         = rem_reg;
        iter_next        = iter_reg;
        res_status_next  = res_status_reg;
        res_where_next   = res_where_reg;
        res_removed_next = res_removed_reg;
        out_valid_next   = out_valid_reg && out_stall;
        status_next      = status_reg;
        position_next    = position_reg;
        removed_next     = removed_reg;
        ram_we           = 1'b0;
        ram_waddr        = h_reg;
        ram_wdata        = item_reg;
        ram_raddr        = h_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next          = operation;
                    item_next        = item_value;
                    pos_next         = slot_position;
                    hs_next          = hs_eff;
                    os_next          = os_eff;
                    cnt_next         = cnt_eff;
                    res_status_next  = hto_pkg::ST_BADPOS;
                    res_where_next   = '0;
                    res_removed_next = hto_pkg::NOTHING;
                    num_next         = hto_pkg::MOD_PAD_W'(item_value);
                    rem_next         = '0;
                    iter_next        = '0;
                    ret_next         = S_HASHED;
                    unique case (operation)
                        hto_pkg::OP_INSERT,
                        hto_pkg::OP_REMOVE_VAL: state_next = S_MOD;
                        hto_pkg::OP_REMOVE_POS: state_next = S_POS;
                        default:                state_next = S_FINISH;
                    endcase
                end
            end

            S_MOD:
            begin
                num_next  = mod_n;
                rem_next  = HW'(mod_r);
                iter_next = iter_reg + 1'b1;
                if (int'(iter_reg) == hto_pkg::MOD_ITER - 1)
                begin
                    state_next = ret_reg;
                end
            end

            S_HASHED:
            begin
                h_next = IW'(rem_reg);
                if (op_reg == hto_pkg::OP_INSERT)
                begin
                    state_next = S_FINISH;
                    if (!occ_reg[IW'(rem_reg)])
                    begin
                        ram_we                    = 1'b1;
                        ram_waddr                 = IW'(rem_reg);
                        occ_next[IW'(rem_reg)]    = 1'b1;
                        res_status_next           = hto_pkg::ST_DONE;
                        res_where_next            = IW'(rem_reg);
                    end
                    else if (cnt_reg < os_reg)
                    begin
                        ram_we             = 1'b1;
                        ram_waddr          = app_addr;
                        occ_next[app_addr] = 1'b1;
                        count_next         = cnt_reg + 1'b1;
                        res_status_next    = hto_pkg::ST_DONE;
                        res_where_next     = app_addr;
                    end
                    else
                    begin
                        res_status_next = hto_pkg::ST_FULL;
                    end
                end
                else
                begin
                    res_status_next = hto_pkg::ST_NOTFOUND;
                    idx_next        = '0;
                    if (occ_reg[IW'(rem_reg)])
                    begin
                        ram_raddr  = IW'(rem_reg);
                        state_next = S_CHKHOME;
                    end
                    else
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end

            S_CHKHOME:
            begin
                if (ram_rdata == item_reg)
                begin
                    res_status_next = hto_pkg::ST_DONE;
                    res_where_next  = h_reg;
                    state_next      = S_FH_RD;
                end
                else
                begin
                    state_next = S_SEARCH;
                end
            end

            S_SEARCH:
            begin
                ram_raddr = ovf_addr;
                if (idx_reg < cnt_reg)
                begin
                    state_next = S_SEARCH_CHK;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_SEARCH_CHK:
            begin
                if (ram_rdata == item_reg)
                begin
                    res_status_next = hto_pkg::ST_DONE;
                    res_where_next  = ovf_addr;
                    state_next      = S_DROP;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SEARCH;
                end
            end

            S_POS:
            begin
                ram_raddr = IW'(pos_reg);
                h_next    = IW'(pos_reg);
                idx_next  = OW'(CW'(pos_reg) - CW'(hs_reg));
                if (CW'(pos_reg) >= CW'(hs_reg) + CW'(os_reg))
                begin
                    state_next = S_FINISH;
                end
                else if (CW'(pos_reg) < CW'(hs_reg))
                begin
                    if (occ_reg[IW'(pos_reg)])
                    begin
                        state_next = S_POS_HOME;
                    end
                    else
                    begin
                        res_status_next = hto_pkg::ST_EMPTY;
                        state_next      = S_FINISH;
                    end
                end
                else if (CW'(pos_reg) - CW'(hs_reg) < CW'(cnt_reg))
                begin
                    state_next = S_POS_OVF;
                end
                else
                begin
                    res_status_next = hto_pkg::ST_EMPTY;
                    state_next      = S_FINISH;
                end
            end

            S_POS_HOME:
            begin
                res_removed_next = ram_rdata;
                res_status_next  = hto_pkg::ST_DONE;
                res_where_next   = h_reg;
                idx_next         = '0;
                state_next       = S_FH_RD;
            end

            S_POS_OVF:
            begin
                res_removed_next = ram_rdata;
                res_status_next  = hto_pkg::ST_DONE;
                res_where_next   = h_reg;
                state_next       = S_DROP;
            end

            S_FH_RD:
            begin
                ram_raddr = ovf_addr;
                if (idx_reg < cnt_reg)
                begin
                    state_next = S_FH_LOAD;
                end
                else
                begin
                    occ_next[h_reg] = 1'b0;
                    state_next      = S_FINISH;
                end
            end

            S_FH_LOAD:
            begin
                val_next   = ram_rdata;
                num_next   = hto_pkg::MOD_PAD_W'(ram_rdata);
                rem_next   = '0;
                iter_next  = '0;
                ret_next   = S_FH_CHK;
                state_next = S_MOD;
            end

            S_FH_CHK:
            begin
                if (IW'(rem_reg) == h_reg)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = h_reg;
                    ram_wdata  = val_reg;
                    state_next = S_DROP;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_FH_RD;
                end
            end

            S_DROP:
            begin
                ram_raddr           = last_addr;
                occ_next[last_addr] = 1'b0;
                count_next          = cnt_reg - 1'b1;
                cnt_next            = cnt_reg - 1'b1;
                state_next          = S_DROP_WR;
            end

            S_DROP_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ovf_addr;
                ram_wdata  = ram_rdata;
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    position_next  = hto_pkg::POS_W'(res_where_reg);
                    removed_next   = res_removed_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            ret_reg           <= S_HASHED;
            table_size_reg    <= hto_pkg::TS_W'(64);
            overflow_size_reg <= hto_pkg::OS_W'(16);
            count_reg         <= '0;
            occ_reg           <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            count_reg     <= count_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                if (cfg_index == hto_pkg::CFG_TABLE_SIZE)
                begin
                    table_size_reg <= cfg_data;
                end
                else
                begin
                    overflow_size_reg <= cfg_data[hto_pkg::OS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        item_reg        <= item_next;
        pos_reg         <= pos_next;
        hs_reg          <= hs_next;
        os_reg          <= os_next;
        cnt_reg         <= cnt_next;
        h_reg           <= h_next;
        idx_reg         <= idx_next;
        val_reg         <= val_next;
        num_reg         <= num_next;
        rem_reg         <= rem_next;
        iter_reg        <= iter_next;
        res_status_reg  <= res_status_next;
        res_where_reg   <= res_where_next;
        res_removed_reg <= res_removed_next;
        status_reg      <= status_next;
        position_reg    <= position_next;
        removed_reg     <= removed_next;
    end

endmodule

### sv/hto_checker.sv
// Port-level checks for the hash table with overflow area, bound to the top.
// Depends on hto_pkg and the assertion macro header.
`include "hash_table_with_overflow_area_defines.svh"

module hto_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [hto_pkg::STATUS_W-1:0]  status,
    input logic [hto_pkg::POS_W-1:0]     position,
    input logic [hto_pkg::ITEM_W-1:0]    removed_value
);

    `HTO_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(status) && $stable(position) && $stable(removed_value),
        "stalled result transfer changed")

    `HTO_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall,
        in_stall, "second item taken while one is in work")

    `HTO_ASSERT_NOW(a_fail_no_position, clk, rst_n,
        out_valid && status != hto_pkg::ST_DONE,
        position == '0 && removed_value == hto_pkg::NOTHING,
        "failed result carries a position or value")

    `HTO_ASSERT_NOW(a_status_code, clk, rst_n, out_valid,
        status == hto_pkg::ST_DONE || status == hto_pkg::ST_FULL ||
        status == hto_pkg::ST_BADPOS || status == hto_pkg::ST_EMPTY ||
        status == hto_pkg::ST_NOTFOUND, "status code out of range")

endmodule

bind hash_table_with_overflow_area hto_checker u_hto_checker (.*);
